[src/ska_pkg.sv]
// ----------------------------------------------------------------------------
// ska_pkg: shared types and constants of the kernel weight accumulator
// Holds store sizes, fixed-point constants, the sequencer state type and the
// reciprocal table used by the Taylor term divide.
// ----------------------------------------------------------------------------
package ska_pkg;

  localparam int NUM_DECAYS = 4;
  localparam int NUM_BINS   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int IDEPTH     = NUM_BINS * NUM_DECAYS;
  localparam int IADDR_W    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
  localparam logic [2:0]  SQUARINGS    = 3'd4;
  localparam logic [31:0] ONE30        = 32'h4000_0000;
  localparam logic [40:0] X_LIMIT      = 41'(12) << 16;
  localparam logic [23:0] CFG_RESET    = 24'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_0 = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_XM, S_XR, S_TM, S_TD, S_TC, S_EV, S_SM, S_SR, S_EF,
    S_AM, S_AR, S_IM, S_IR, S_GM, S_GR, S_DM, S_DR, S_BU, S_ORD, S_OSH
  } state_t;

  // floor(2^32 / k), capped to 32 bits; quotient estimate is low by at most one
  function automatic logic [31:0] recip_k(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd1:    m = 32'hFFFF_FFFF;
      4'd2:    m = 32'h8000_0000;
      4'd3:    m = 32'h5555_5555;
      4'd4:    m = 32'h4000_0000;
      4'd5:    m = 32'h3333_3333;
      4'd6:    m = 32'h2AAA_AAAA;
      4'd7:    m = 32'h2492_4924;
      4'd8:    m = 32'h2000_0000;
      4'd9:    m = 32'h1C71_C71C;
      4'd10:   m = 32'h1999_9999;
      4'd11:   m = 32'h1745_D174;
      4'd12:   m = 32'h1555_5555;
      default: m = 32'h0;
    endcase
    return m;
  endfunction

endpackage

[src/ska_if.sv]
// ----------------------------------------------------------------------------
// ska_if: beat channels of the kernel weight accumulator
// Input channel carries one interval or read request, output channel carries
// one per-decay result.
// ----------------------------------------------------------------------------
interface ska_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] delta_time;
  logic [3:0]  state_bin;
  logic        prev_own;
  logic        cur_own;
  logic        is_final;
  modport source(output valid, func, delta_time, state_bin, prev_own, cur_own, is_final,
                 input ready);
  modport sink(input valid, func, delta_time, state_bin, prev_own, cur_own, is_final,
               output ready);
endinterface

interface ska_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  decay_index;
  logic [31:0] kernel_value;
  logic [47:0] integral_value;
  logic [15:0] event_count;
  logic [47:0] occupied_time;
  logic        last;
  modport source(output valid, decay_index, kernel_value, integral_value, event_count,
                 occupied_time, last, input ready);
  modport sink(input valid, decay_index, kernel_value, integral_value, event_count,
               occupied_time, last, output ready);
endinterface

[src/sumexp_kernel_weight_accumulator_top.sv]
// ----------------------------------------------------------------------------
// sumexp_kernel_weight_accumulator_top: sum-of-exponentials kernel accumulator
// Sequence: a process beat runs the decays in turn (the exponent series is
//   skipped when it underflows to zero), then updates the bin store; every
//   beat then shows one result per decay. Flow: one beat at a time, taken in
//   idle after the last result; all steps share the single 32x32 multiplier.
// Reset: rst_n low clears kernels, bin counts and times, integral valid bits
//   and sets all decay and recip registers to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sumexp_kernel_weight_accumulator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  ska_in_if.sink                         in_if,
  ska_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [ska_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ska_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ska_pkg::*;

  // sequencer and captured beat
  state_t      st_r, st_nxt;
  logic [1:0]  u_r;
  logic [3:0]  k_r;
  logic [2:0]  sq_r;
  logic        prev_r, cur_r, fin_r;
  logic [31:0] delta_r;
  logic [3:0]  bin_r;

  // exponent datapath
  logic [29:0] r_r;
  logic [30:0] term_r, t_r, v_r;
  logic [31:0] pos_r, neg_r;
  logic [16:0] e_r;
  logic [24:0] a_r;
  logic [31:0] gt_r;
  logic [63:0] p_r;

  // configuration and state stores
  logic [23:0] dec_r [NUM_DECAYS];
  logic [23:0] rec_r [NUM_DECAYS];
  logic [31:0] kern_r [NUM_DECAYS];
  logic [15:0] cnt_r [NUM_BINS];
  logic [47:0] tim_r [NUM_BINS];
  logic [47:0] imem [IDEPTH];
  logic [IDEPTH-1:0] ivld_r;
  logic [47:0] rd_r;
  logic        rd_vld_r;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [BIN_AW-1:0]  bidx;
  logic [IADDR_W-1:0] iaddr;
  logic        bin_ok;
  logic [47:0] rnd_p;
  logic [40:0] x_val;
  logic [16:0] om;
  logic [31:0] q0;
  logic [35:0] qk, rem;
  logic [30:0] q;
  logic [31:0] dsum;
  logic [47:0] istore;
  logic [41:0] iadd;
  logic [48:0] isum, tsum;
  logic [32:0] gsum;
  logic        iwe;

  assign bidx   = BIN_AW'({5'd0, bin_r});
  assign bin_ok = ({5'd0, bin_r} < 9'(NUM_BINS));
  assign iaddr  = IADDR_W'(int'(bidx) * NUM_DECAYS + int'(u_r));
  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign rnd_p  = 48'((p_r + 64'h8000) >> 16);
  assign x_val  = rnd_p[40:0];
  assign om     = 17'd65536 - e_r;

  // quotient correction for the Taylor divide
  assign q0   = p_r[63:32];
  assign qk   = 36'(q0) * 36'(k_r);
  assign rem  = {5'd0, t_r} - qk;
  assign q    = (rem >= 36'(k_r)) ? 31'(q0 + 32'd1) : q0[30:0];
  assign dsum = (k_r[0] ? neg_r : pos_r) + 32'(q);

  assign istore = rd_vld_r ? rd_r : 48'd0;
  assign iadd   = 42'(rnd_p[40:0]) + (prev_r ? 42'(om) : 42'd0);
  assign isum   = {1'b0, istore} + 49'(iadd);
  assign iwe    = (st_r == S_IR) && !fin_r && bin_ok;
  assign gsum   = {1'b0, gt_r} + (prev_r ? 33'(rnd_p[24:0]) : 33'd0);
  assign tsum   = {1'b0, tim_r[bidx]} + 49'(delta_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_if.valid) st_nxt = in_if.func ? S_ORD : S_XM;
      S_XM:   st_nxt = S_XR;
      S_XR:   st_nxt = (x_val >= X_LIMIT) ? S_AM : S_TM;
      S_TM:   st_nxt = S_TD;
      S_TD:   st_nxt = S_TC;
      S_TC:   st_nxt = (k_r == TAYLOR_TERMS) ? S_EV : S_TM;
      S_EV:   st_nxt = S_SM;
      S_SM:   st_nxt = S_SR;
      S_SR:   st_nxt = (sq_r == SQUARINGS - 3'd1) ? S_EF : S_SM;
      S_EF:   st_nxt = S_AM;
      S_AM:   st_nxt = S_AR;
      S_AR:   st_nxt = S_IM;
      S_IM:   st_nxt = S_IR;
      S_IR:   st_nxt = S_GM;
      S_GM:   st_nxt = S_GR;
      S_GR:   st_nxt = S_DM;
      S_DM:   st_nxt = S_DR;
      S_DR:   st_nxt = (u_r == 2'(NUM_DECAYS - 1)) ? S_BU : S_XM;
      S_BU:   st_nxt = S_ORD;
      S_ORD:  st_nxt = S_OSH;
      S_OSH: begin
        if (out_if.ready) st_nxt = (u_r == 2'(NUM_DECAYS - 1)) ? S_IDLE : S_ORD;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // handshake and multiplier operand select
  always_comb begin
    in_if.ready  = (st_r == S_IDLE);
    out_if.valid = (st_r == S_OSH);
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (st_r)
      S_XM: begin
        mul_a = 32'(dec_r[u_r]);
        mul_b = delta_r;
      end
      S_TM: begin
        mul_a = 32'(term_r);
        mul_b = 32'(r_r);
      end
      S_TD: begin
        mul_a = 32'(p_r[60:30]);
        mul_b = recip_k(k_r);
      end
      S_SM: begin
        mul_a = 32'(v_r);
        mul_b = 32'(v_r);
      end
      S_AM: begin
        mul_a = 32'(om);
        mul_b = 32'(rec_r[u_r]);
      end
      S_IM: begin
        mul_a = 32'(a_r);
        mul_b = kern_r[u_r];
      end
      S_GM: begin
        mul_a = kern_r[u_r];
        mul_b = 32'(e_r);
      end
      S_DM: begin
        mul_a = 32'(dec_r[u_r]);
        mul_b = 32'(e_r);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // result beat
  always_comb begin
    out_if.decay_index    = u_r;
    out_if.kernel_value   = kern_r[u_r];
    out_if.integral_value = bin_ok ? istore : 48'd0;
    out_if.event_count    = bin_ok ? cnt_r[bidx] : 16'd0;
    out_if.occupied_time  = bin_ok ? tim_r[bidx] : 48'd0;
    out_if.last           = (u_r == 2'(NUM_DECAYS - 1));
  end

  // multiplier output register and integral store
  always_ff @(posedge clk) begin
    p_r <= prod;
    if (iwe) imem[iaddr] <= isum[48] ? {48{1'b1}} : isum[47:0];
    rd_r     <= imem[iaddr];
    rd_vld_r <= ivld_r[iaddr];
  end

  // control state, configuration and small stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      u_r    <= 2'd0;
      k_r    <= 4'd1;
      sq_r   <= 3'd0;
      ivld_r <= '0;
      for (int i = 0; i < NUM_DECAYS; i++) begin
        dec_r[i]  <= CFG_RESET;
        rec_r[i]  <= CFG_RESET;
        kern_r[i] <= 32'd0;
      end
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_r[i] <= 16'd0;
        tim_r[i] <= 48'd0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index < CFG_RECIP_0) dec_r[2'(cfg_index - CFG_DECAY_0)] <= cfg_data;
        else rec_r[2'(cfg_index - CFG_RECIP_0)] <= cfg_data;
      end
      if (iwe) ivld_r[iaddr] <= 1'b1;
      case (st_r)
        S_IDLE: u_r <= 2'd0;
        S_TC:   k_r <= k_r + 4'd1;
        S_EV:   sq_r <= 3'd0;
        S_SR:   sq_r <= sq_r + 3'd1;
        S_XR:   k_r <= 4'd1;
        S_DR: begin
          kern_r[u_r] <= gsum[32] ? 32'hFFFF_FFFF : gsum[31:0];
          u_r <= (u_r == 2'(NUM_DECAYS - 1)) ? 2'd0 : u_r + 2'd1;
        end
        S_BU: begin
          if (bin_ok) begin
            tim_r[bidx] <= tsum[48] ? {48{1'b1}} : tsum[47:0];
            if (cur_r && !fin_r && cnt_r[bidx] != 16'hFFFF)
              cnt_r[bidx] <= cnt_r[bidx] + 16'd1;
          end
        end
        S_OSH: if (out_if.ready) u_r <= u_r + 2'd1;
        default: ;
      endcase
    end
  end

  // exponent and product datapath, no reset needed
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (in_if.valid) begin
          delta_r <= in_if.delta_time;
          bin_r   <= in_if.state_bin;
          prev_r  <= in_if.prev_own;
          cur_r   <= in_if.cur_own;
          fin_r   <= in_if.is_final;
        end
      end
      S_XR: begin
        // underflow: drop the series, e is zero
        if (x_val >= X_LIMIT) e_r <= 17'd0;
        r_r    <= {x_val[19:0], 10'd0};
        term_r <= ONE30[30:0];
        pos_r  <= ONE30;
        neg_r  <= 32'd0;
      end
      S_TD: t_r <= p_r[60:30];
      S_TC: begin
        term_r <= q;
        if (k_r[0]) neg_r <= dsum;
        else pos_r <= dsum;
      end
      S_EV: begin
        if (pos_r <= neg_r) v_r <= 31'd0;
        else if (pos_r - neg_r > ONE30) v_r <= ONE30[30:0];
        else v_r <= 31'(pos_r - neg_r);
      end
      S_SR: v_r <= 31'((p_r + 64'h2000_0000) >> 30);
      S_EF: e_r <= 17'((32'(v_r) + 32'h2000) >> 14);
      S_AR: a_r <= rnd_p[24:0];
      S_GR: gt_r <= rnd_p[31:0];
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input accepted while a result is shown");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.last) |-> (out_if.decay_index == 2'(NUM_DECAYS - 1)))
    else $error("last flag on wrong decay");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TC) |-> (k_r >= 4'd1 && k_r <= TAYLOR_TERMS))
    else $error("Taylor step out of range");

  a_v_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SM) |-> (v_r <= ONE30[30:0]))
    else $error("squaring operand above one");

  a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_AM) |-> (e_r <= 17'd65536))
    else $error("exponential above one");

endmodule
